// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, removed when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/mfhp_pkg.sv -----
// ----------------------------------------------------------------------------
// mfhp_pkg
// types, codes and header length function of the mac frame header parser
// ----------------------------------------------------------------------------
package mfhp_pkg;

  localparam logic [1:0] ADDR_MODE_NONE  = 2'd0;
  localparam logic [1:0] ADDR_MODE_SHORT = 2'd2;
  localparam logic [1:0] ADDR_MODE_EXT   = 2'd3;

  localparam logic ERR_TOO_SHORT = 1'b0;
  localparam logic ERR_ADDR_MODE = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic [9:0] frame_length;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [7:0]  seq_number;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
    logic [2:0]  frame_type;
    logic        frame_pending;
    logic        ack_request;
    logic [9:0]  payload_length;
    logic        error_code;
  } result_t;

  function automatic logic [4:0] addr_size(input logic [1:0] mode);
    logic [4:0] n;
    n = 5'd0;
    if (mode == ADDR_MODE_SHORT) n = 5'd2;
    else if (mode == ADDR_MODE_EXT) n = 5'd8;
    return n;
  endfunction

  function automatic logic [4:0] header_len(input logic [15:0] cw);
    logic [1:0] dmode;
    logic [1:0] smode;
    logic       comp;
    logic [4:0] n;
    dmode = cw[11:10];
    smode = cw[15:14];
    comp  = cw[6];
    n = 5'd3;
    if (dmode != ADDR_MODE_NONE) n = n + 5'd2;
    n = n + addr_size(dmode);
    if (smode != ADDR_MODE_NONE && !(comp && dmode != ADDR_MODE_NONE)) n = n + 5'd2;
    n = n + addr_size(smode);
    return n;
  endfunction

endpackage

// ----- rtl/mfhp_parse.sv -----
// ----------------------------------------------------------------------------
// mfhp_parse
// per-byte frame state and decode of one registered byte into a result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfhp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  mfhp_pkg::in_item_t item,
  output logic               res_valid,
  output mfhp_pkg::result_t  res
);

  logic [9:0]  pos_r, pos_nxt;
  logic [15:0] cw_r, cw_nxt;
  logic [4:0]  hl_r, hl_nxt;
  logic [9:0]  lif_r, lif_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] dest_r, dest_nxt;
  logic [15:0] src_r, src_nxt;
  logic        discard_r, discard_nxt;

  logic [9:0]  pos_c;
  logic [15:0] cw_c;
  logic [4:0]  hl_c;
  logic [9:0]  lif_c;
  logic [7:0]  seq_c;
  logic [15:0] dest_c;
  logic [15:0] src_c;
  logic [15:0] cw_full;
  logic [4:0]  hl_full;
  logic [9:0]  sbase;
  logic        active;

  always_comb begin
    pos_nxt     = pos_r;
    cw_nxt      = cw_r;
    hl_nxt      = hl_r;
    lif_nxt     = lif_r;
    seq_nxt     = seq_r;
    dest_nxt    = dest_r;
    src_nxt     = src_r;
    discard_nxt = discard_r;
    res_valid   = 1'b0;
    res         = '0;

    active = item.first_byte || !discard_r;
    pos_c  = item.first_byte ? 10'd0 : pos_r;
    cw_c   = item.first_byte ? 16'd0 : cw_r;
    hl_c   = item.first_byte ? 5'd0 : hl_r;
    lif_c  = item.first_byte ? item.frame_length : lif_r;
    seq_c  = item.first_byte ? 8'd0 : seq_r;
    dest_c = item.first_byte ? 16'd0 : dest_r;
    src_c  = item.first_byte ? 16'd0 : src_r;

    cw_full = {item.data_byte, cw_c[7:0]};
    hl_full = mfhp_pkg::header_len(cw_full);
    sbase   = cw_c[6] ? 10'd7 : 10'd9;

    if (fire && active) begin
      discard_nxt = 1'b0;
      lif_nxt     = lif_c;
      cw_nxt      = cw_c;
      hl_nxt      = hl_c;
      seq_nxt     = seq_c;
      dest_nxt    = dest_c;
      src_nxt     = src_c;
      pos_nxt     = pos_c + 10'd1;

      if (pos_c == 10'd0) begin
        cw_nxt = {8'd0, item.data_byte};
        if (lif_c <= 10'd2) begin
          res_valid      = 1'b1;
          res.kind       = mfhp_pkg::KIND_ERROR;
          res.error_code = mfhp_pkg::ERR_TOO_SHORT;
          discard_nxt    = 1'b1;
        end
      end else if (pos_c == 10'd1) begin
        cw_nxt = cw_full;
        hl_nxt = hl_full;
        if ({1'b0, lif_c} <= {6'd0, hl_full} + 11'd2) begin
          res_valid      = 1'b1;
          res.kind       = mfhp_pkg::KIND_ERROR;
          res.error_code = mfhp_pkg::ERR_TOO_SHORT;
          discard_nxt    = 1'b1;
        end else if (cw_full[11:10] != mfhp_pkg::ADDR_MODE_SHORT ||
                     cw_full[15:14] != mfhp_pkg::ADDR_MODE_SHORT) begin
          res_valid      = 1'b1;
          res.kind       = mfhp_pkg::KIND_ERROR;
          res.error_code = mfhp_pkg::ERR_ADDR_MODE;
          discard_nxt    = 1'b1;
        end
      end else if (pos_c < {5'd0, hl_c}) begin
        if (pos_c == 10'd2) seq_nxt = item.data_byte;
        else if (pos_c == 10'd5) dest_nxt = {dest_c[15:8], item.data_byte};
        else if (pos_c == 10'd6) dest_nxt = {item.data_byte, dest_c[7:0]};
        else if (pos_c == sbase) src_nxt = {src_c[15:8], item.data_byte};
        else if (pos_c == sbase + 10'd1) src_nxt = {item.data_byte, src_c[7:0]};
        if (pos_c == {5'd0, hl_c - 5'd1}) begin
          res_valid          = 1'b1;
          res.kind           = mfhp_pkg::KIND_HEADER;
          res.seq_number     = seq_nxt;
          res.dest_addr      = dest_nxt;
          res.src_addr       = src_nxt;
          res.frame_type     = cw_c[2:0];
          res.frame_pending  = cw_c[4];
          res.ack_request    = cw_c[5];
          res.payload_length = lif_c - {5'd0, hl_c} - 10'd2;
        end
      end else if ({1'b0, pos_c} + 11'd2 < {1'b0, lif_c}) begin
        res_valid        = 1'b1;
        res.kind         = mfhp_pkg::KIND_PAYLOAD;
        res.payload_byte = item.data_byte;
        res.last_payload = ({1'b0, pos_c} + 11'd3 == {1'b0, lif_c});
      end else if ({1'b0, pos_c} + 11'd1 >= {1'b0, lif_c}) begin
        discard_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      cw_r      <= '0;
      hl_r      <= '0;
      lif_r     <= '0;
      seq_r     <= '0;
      dest_r    <= '0;
      src_r     <= '0;
      discard_r <= 1'b1;
    end else begin
      pos_r     <= pos_nxt;
      cw_r      <= cw_nxt;
      hl_r      <= hl_nxt;
      lif_r     <= lif_nxt;
      seq_r     <= seq_nxt;
      dest_r    <= dest_nxt;
      src_r     <= src_nxt;
      discard_r <= discard_nxt;
    end
  end

  `ASSERT_NEXT(a_error_discards, clk, rst_n, res_valid && res.kind == mfhp_pkg::KIND_ERROR, discard_r)
  `ASSERT_IMPLY(a_header_short_modes, clk, rst_n, res_valid && res.kind == mfhp_pkg::KIND_HEADER, cw_r[11:10] == mfhp_pkg::ADDR_MODE_SHORT && cw_r[15:14] == mfhp_pkg::ADDR_MODE_SHORT)
  `ASSERT_IMPLY(a_payload_after_header, clk, rst_n, res_valid && res.kind == mfhp_pkg::KIND_PAYLOAD, hl_r != 5'd0 && pos_r >= {5'd0, hl_r})

endmodule

// ----- rtl/mfhp_out_reg.sv -----
// ----------------------------------------------------------------------------
// mfhp_out_reg
// result register that holds a result until the receiving side takes it
// ----------------------------------------------------------------------------
module mfhp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              res_valid,
  input  mfhp_pkg::result_t res,
  input  logic              out_stall,
  output logic              can_load,
  output logic              out_valid,
  output mfhp_pkg::result_t out_res
);

  logic              valid_r;
  mfhp_pkg::result_t res_r;

  assign can_load  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ----- rtl/mac_frame_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// mac_frame_header_parser_top: 802.15.4 mac header parser, one byte per cycle unless stalled
// structure: input byte register, combinational decode, output result register
// throughput: one byte per cycle while the output is not stalled, set by the single-pass decode stage
// reset: parser idle until a byte with first_byte; no results pending
// ----------------------------------------------------------------------------
module mac_frame_header_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [9:0]  in_frame_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_payload,
  output logic [7:0]  out_seq_number,
  output logic [15:0] out_dest_addr,
  output logic [15:0] out_src_addr,
  output logic [2:0]  out_frame_type,
  output logic        out_frame_pending,
  output logic        out_ack_request,
  output logic [9:0]  out_payload_length,
  output logic        out_error_code
);

  logic               in_valid_r;
  mfhp_pkg::in_item_t item_r;
  logic               can_load;
  logic               fire;
  logic               res_valid;
  mfhp_pkg::result_t  res;
  mfhp_pkg::result_t  out_res;

  assign fire     = in_valid_r && can_load;
  assign in_stall = in_valid_r && !can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= '{data_byte: in_data_byte, first_byte: in_first_byte,
                  frame_length: in_frame_length};
    end
  end

  mfhp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mfhp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_last_payload   = out_res.last_payload;
  assign out_seq_number     = out_res.seq_number;
  assign out_dest_addr      = out_res.dest_addr;
  assign out_src_addr       = out_res.src_addr;
  assign out_frame_type     = out_res.frame_type;
  assign out_frame_pending  = out_res.frame_pending;
  assign out_ack_request    = out_res.ack_request;
  assign out_payload_length = out_res.payload_length;
  assign out_error_code     = out_res.error_code;

endmodule

// ----- tb/tb_mac_frame_header_parser_top.sv -----
// ----------------------------------------------------------------------------
// tb_mac_frame_header_parser_top
// feeds 802.15.4 frames byte by byte into the header parser and checks every
// header record, payload byte and error against a cycle-free parser model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_mac_frame_header_parser_top;

  localparam int ITEMS       = 1900;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 250;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN       = 20;

  class header_scoreboard;
    mfhp_pkg::result_t pending_results[$];
    int          errors;
    int          checked;
    logic [9:0]  pos;
    logic [9:0]  flen;
    logic [15:0] ctrl;
    logic [4:0]  hdr;
    logic [7:0]  seq;
    logic [15:0] dst;
    logic [15:0] src;
    bit          parked;

    function new();
      errors  = 0;
      checked = 0;
      parked  = 1'b1;
      pos     = '0;
      flen    = '0;
      ctrl    = '0;
      hdr     = '0;
      seq     = '0;
      dst     = '0;
      src     = '0;
    endfunction

    function void parse_byte(logic [7:0] d, logic first, logic [9:0] len);
      mfhp_pkg::result_t r;
      logic [9:0] p;
      int         sbase;
      bit         emit;
      r    = '0;
      emit = 1'b0;
      if (first) begin
        parked = 1'b0;
        pos    = '0;
        flen   = len;
        ctrl   = '0;
        hdr    = '0;
        seq    = '0;
        dst    = '0;
        src    = '0;
      end else if (parked) begin
        return;
      end
      p   = pos;
      pos = pos + 10'd1;
      if (p == 10'd0) begin
        ctrl = {8'h00, d};
        if (flen <= 10'd2) begin
          r.kind       = mfhp_pkg::KIND_ERROR;
          r.error_code = mfhp_pkg::ERR_TOO_SHORT;
          emit         = 1'b1;
          parked       = 1'b1;
        end
      end else if (p == 10'd1) begin
        ctrl[15:8] = d;
        // control, sequence, pan ids and both addresses
        hdr = 5'd3;
        if (ctrl[11:10] != mfhp_pkg::ADDR_MODE_NONE) hdr = hdr + 5'd2;
        if (ctrl[11:10] == mfhp_pkg::ADDR_MODE_SHORT) hdr = hdr + 5'd2;
        else if (ctrl[11:10] == mfhp_pkg::ADDR_MODE_EXT) hdr = hdr + 5'd8;
        if (ctrl[15:14] != mfhp_pkg::ADDR_MODE_NONE &&
            (!ctrl[6] || ctrl[11:10] == mfhp_pkg::ADDR_MODE_NONE))
          hdr = hdr + 5'd2;
        if (ctrl[15:14] == mfhp_pkg::ADDR_MODE_SHORT) hdr = hdr + 5'd2;
        else if (ctrl[15:14] == mfhp_pkg::ADDR_MODE_EXT) hdr = hdr + 5'd8;
        if (int'(flen) <= int'(hdr) + 2) begin
          r.kind       = mfhp_pkg::KIND_ERROR;
          r.error_code = mfhp_pkg::ERR_TOO_SHORT;
          emit         = 1'b1;
          parked       = 1'b1;
        end else if (ctrl[11:10] != mfhp_pkg::ADDR_MODE_SHORT ||
                     ctrl[15:14] != mfhp_pkg::ADDR_MODE_SHORT) begin
          r.kind       = mfhp_pkg::KIND_ERROR;
          r.error_code = mfhp_pkg::ERR_ADDR_MODE;
          emit         = 1'b1;
          parked       = 1'b1;
        end
      end else if (int'(p) < int'(hdr)) begin
        sbase = ctrl[6] ? 7 : 9;
        if (p == 10'd2) seq = d;
        else if (p == 10'd5) dst[7:0] = d;
        else if (p == 10'd6) dst[15:8] = d;
        else if (int'(p) == sbase) src[7:0] = d;
        else if (int'(p) == sbase + 1) src[15:8] = d;
        if (int'(p) == int'(hdr) - 1) begin
          r.kind           = mfhp_pkg::KIND_HEADER;
          r.seq_number     = seq;
          r.dest_addr      = dst;
          r.src_addr       = src;
          r.frame_type     = ctrl[2:0];
          r.frame_pending  = ctrl[4];
          r.ack_request    = ctrl[5];
          r.payload_length = flen - 10'(hdr) - 10'd2;
          emit             = 1'b1;
        end
      end else if (int'(p) + 2 < int'(flen)) begin
        r.kind         = mfhp_pkg::KIND_PAYLOAD;
        r.payload_byte = d;
        r.last_payload = (int'(p) + 3 == int'(flen));
        emit           = 1'b1;
      end else if (int'(p) + 1 >= int'(flen)) begin
        parked = 1'b1;
      end
      if (emit) pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got_v, logic [15:0] want_v);
      if (got_v !== want_v)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, want_v));
    endtask

    task check_result(mfhp_pkg::result_t got);
      mfhp_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result of kind %0d", got.kind));
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", 16'(got.kind), 16'(want.kind));
        compare_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
        compare_field("last_payload", 16'(got.last_payload), 16'(want.last_payload));
        compare_field("seq_number", 16'(got.seq_number), 16'(want.seq_number));
        compare_field("dest_addr", got.dest_addr, want.dest_addr);
        compare_field("src_addr", got.src_addr, want.src_addr);
        compare_field("frame_type", 16'(got.frame_type), 16'(want.frame_type));
        compare_field("frame_pending", 16'(got.frame_pending), 16'(want.frame_pending));
        compare_field("ack_request", 16'(got.ack_request), 16'(want.ack_request));
        compare_field("payload_length", 16'(got.payload_length),
                      16'(want.payload_length));
        compare_field("error_code", 16'(got.error_code), 16'(want.error_code));
      end
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_first_byte = 1'b0;
  logic [9:0]  in_frame_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic        out_last_payload;
  logic [7:0]  out_seq_number;
  logic [15:0] out_dest_addr;
  logic [15:0] out_src_addr;
  logic [2:0]  out_frame_type;
  logic        out_frame_pending;
  logic        out_ack_request;
  logic [9:0]  out_payload_length;
  logic        out_error_code;

  header_scoreboard sb = new();

  int bytes_in = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit hold_active = 1'b0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;

  mac_frame_header_parser_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_frame_length    (in_frame_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_last_payload   (out_last_payload),
    .out_seq_number     (out_seq_number),
    .out_dest_addr      (out_dest_addr),
    .out_src_addr       (out_src_addr),
    .out_frame_type     (out_frame_type),
    .out_frame_pending  (out_frame_pending),
    .out_ack_request    (out_ack_request),
    .out_payload_length (out_payload_length),
    .out_error_code     (out_error_code)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (quiet || hold_active) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] d, logic f, logic [9:0] l);
    int gap;
    in_valid        <= 1'b1;
    in_data_byte    <= d;
    in_first_byte   <= f;
    in_frame_length <= l;
    do @(posedge clk); while (in_stall);
    sb.parse_byte(d, f, l);
    bytes_in++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_frame(logic [15:0] cw, logic [9:0] len, int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if (i == 0) send_byte(cw[7:0], 1'b1, len);
      else if (i == 1) send_byte(cw[15:8], 1'b0, 10'($urandom));
      else send_byte(8'($urandom), 1'b0, 10'($urandom));
      items_sent++;
    end
  endtask

  initial begin
    logic [15:0] cw;
    int          r;
    int          hl;
    int          plen;
    int          len;
    int          nb;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // stray byte with no frame open
    send_byte(8'hff, 1'b0, 10'h3ff);
    // frames of length 0 and 2
    send_byte(8'h00, 1'b1, 10'd0);
    send_byte(8'hff, 1'b1, 10'd2);
    // extended addressing
    send_frame(16'hffff, 10'd1023, 2);
    // short addressing but no room for header and crc
    send_frame(16'h8841, 10'd11, 2);
    // abandoned by a new frame
    send_frame(16'h8861, 10'd20, 3);
    // compressed pan id, one payload byte, pending and ack bits set
    send_frame(16'h8871, 10'd12, 12);
    send_byte(8'h00, 1'b0, 10'd0);

    while (items_sent < ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      cw = 16'($urandom);
      if (r < 85) begin
        cw[11:10] = mfhp_pkg::ADDR_MODE_SHORT;
        cw[15:14] = mfhp_pkg::ADDR_MODE_SHORT;
      end
      hl = cw[6] ? 9 : 11;
      if (r < 75) begin
        if ($urandom_range(0, 99) == 0) plen = $urandom_range(200, 1021 - hl);
        else plen = $urandom_range(1, 24);
        len = hl + 2 + plen;
        nb = len;
        if ($urandom_range(0, 9) == 0) nb = $urandom_range(1, len - 1);
        send_frame(cw, 10'(len), nb);
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 10'($urandom));
      end else if (r < 85) begin
        send_frame(cw, 10'($urandom_range(0, hl + 2)), $urandom_range(1, 4));
      end else begin
        len = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 1023);
        send_frame(cw, 10'(len), $urandom_range(1, 28));
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver back pressure, with one long hold-off to fill the block
  initial begin
    int len;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && bytes_in >= HOLD_AT) begin
        out_stall   <= 1'b1;
        hold_active = 1'b1;
        hold_done   = 1'b1;
        len         = HOLD_CYCLES;
      end else begin
        hold_active = 1'b0;
        case ($urandom_range(0, 99)) inside
          [0:54]: begin
            out_stall <= 1'b0;
            len = $urandom_range(1, 30);
          end
          [55:91]: begin
            out_stall <= 1'b1;
            len = $urandom_range(1, 4);
          end
          default: begin
            out_stall <= 1'b1;
            len = $urandom_range(10, 40);
          end
        endcase
      end
      repeat (len - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_monitor
    mfhp_pkg::result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind           = mfhp_pkg::kind_t'(out_kind);
      got.payload_byte   = out_payload_byte;
      got.last_payload   = out_last_payload;
      got.seq_number     = out_seq_number;
      got.dest_addr      = out_dest_addr;
      got.src_addr       = out_src_addr;
      got.frame_type     = out_frame_type;
      got.frame_pending  = out_frame_pending;
      got.ack_request    = out_ack_request;
      got.payload_length = out_payload_length;
      got.error_code     = out_error_code;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
